/* sv/mexp_pkg.sv */
// shared widths, constants and state type for the modular exponentiation block
package mexp_pkg;

    localparam int FIELD_W = 63;
    localparam int MOD_W   = 31;
    localparam int RCNT_W  = 6;
    localparam int MCNT_W  = 5;

    localparam logic [MOD_W-1:0]  MODULUS_RESET = 31'd1000000007;
    localparam logic [RCNT_W-1:0] RCNT_LAST     = 6'(FIELD_W - 1);
    localparam logic [MCNT_W-1:0] MCNT_LAST     = 5'(MOD_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL_ACC,
        ST_MUL_SQ,
        ST_FINISH
    } mexp_state_t;

endpackage

/* sv/mexp_if.sv */
// valid/ready channel interfaces for input and result words
interface mexp_in_if
    import mexp_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] base_value;
    logic [FIELD_W-1:0] power;

    modport source (output valid, output base_value, output power, input ready);
    modport sink   (input valid, input base_value, input power, output ready);
endinterface

interface mexp_out_if
    import mexp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [MOD_W-1:0] residue;

    modport source (output valid, output residue, input ready);
    modport sink   (input valid, input residue, output ready);
endinterface

/* sv/modular_exponentiation.sv */
// Modular exponentiation: residue = base_value ** power mod modulus, computed right to left
// over the exponent bits with square-and-multiply. One word is worked on at a time.
// The base is first reduced bit-serially, one bit per cycle. Each exponent bit
// then takes a check state and a squaring, plus a multiply of the running result by the
// current square when the bit is set, all on a single shared bit-serial modular multiplier.
// The result word is registered from the finish state once the power has shifted to zero.
// A stalled receiver adds its stall once the output register is full, and the next word
// can be accepted at the edge after the result is registered. A zero power returns 1
// unreduced. A modulus of zero acts as one.
// The modulus may only be written while no word is in flight.
module modular_exponentiation
    import mexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [MOD_W-1:0] cfg_wdata,
    mexp_in_if.sink          in_ch,
    mexp_out_if.source       out_ch
);

    mexp_state_t        state_reg, state_next;
    logic [MOD_W-1:0]   modulus_reg;
    logic [FIELD_W-1:0] base_reg, base_next;
    logic [FIELD_W-1:0] exp_reg, exp_next;
    logic [MOD_W-1:0]   m_reg, m_next;
    logic [MOD_W-1:0]   acc_reg, acc_next;
    logic [MOD_W-1:0]   sq_reg, sq_next;
    logic [RCNT_W-1:0]  cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [MOD_W-1:0]   residue_reg, residue_next;
    logic [MOD_W:0]     red_val;
    logic               mm_start;
    logic [MOD_W-1:0]   mm_a;
    logic               mm_done;
    logic [MOD_W-1:0]   mm_result;

    // shared modular multiplier
    mexp_mulmod u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mm_start),
        .a      (mm_a),
        .b      (sq_reg),
        .m      (m_reg),
        .done   (mm_done),
        .result (mm_result)
    );

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MODULUS_RESET;
        end
        else if (cfg_we)
        begin
            modulus_reg <= cfg_wdata;
        end
    end

    // base reduction step: shift in one base bit, subtract modulus once
    always_comb
    begin
        red_val = {sq_reg, base_reg[FIELD_W-1]};
        if (red_val >= {1'b0, m_reg})
        begin
            red_val = red_val - {1'b0, m_reg};
        end
    end

    // next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        m_next         = m_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        residue_next   = residue_reg;
        mm_start       = 1'b0;
        mm_a           = sq_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    base_next  = in_ch.base_value;
                    exp_next   = in_ch.power;
                    m_next     = (modulus_reg == '0) ? MOD_W'(1) : modulus_reg;
                    acc_next   = MOD_W'(1);
                    sq_next    = '0;
                    cnt_next   = '0;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                sq_next   = red_val[MOD_W-1:0];
                base_next = {base_reg[FIELD_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == RCNT_LAST)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (exp_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (exp_reg[0])
                begin
                    mm_start   = 1'b1;
                    mm_a       = acc_reg;
                    state_next = ST_MUL_ACC;
                end
                else
                begin
                    mm_start   = 1'b1;
                    state_next = ST_MUL_SQ;
                end
            end
            ST_MUL_ACC:
            begin
                if (mm_done)
                begin
                    acc_next   = mm_result;
                    mm_start   = 1'b1;
                    state_next = ST_MUL_SQ;
                end
            end
            ST_MUL_SQ:
            begin
                if (mm_done)
                begin
                    sq_next    = mm_result;
                    exp_next   = {1'b0, exp_reg[FIELD_W-1:1]};
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    residue_next   = acc_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        exp_reg     <= exp_next;
        m_reg       <= m_next;
        acc_reg     <= acc_next;
        sq_reg      <= sq_next;
        residue_reg <= residue_next;
    end

    assign in_ch.ready    = (state_reg == ST_IDLE);
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.residue = residue_reg;

endmodule

/* sv/mexp_mulmod.sv */
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
module mexp_mulmod
    import mexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MOD_W-1:0] a,
    input  logic [MOD_W-1:0] b,
    input  logic [MOD_W-1:0] m,
    output logic             done,
    output logic [MOD_W-1:0] result
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [MCNT_W-1:0] cnt_reg, cnt_next;
    logic [MOD_W-1:0]  a_reg, a_next;
    logic [MOD_W-1:0]  b_reg, b_next;
    logic [MOD_W-1:0]  m_reg, m_next;
    logic [MOD_W-1:0]  r_reg, r_next;
    logic [MOD_W:0]    dbl;
    logic [MOD_W:0]    dbl_red;
    logic [MOD_W:0]    sum;
    logic [MOD_W:0]    sum_red;

    // one step: r = 2r mod m, then add b mod m when the multiplier bit is set
    always_comb
    begin
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        sum     = a_reg[MOD_W-1] ? dbl_red + {1'b0, b_reg} : dbl_red;
        sum_red = (sum >= {1'b0, m_reg}) ? sum - {1'b0, m_reg} : sum;
    end

    // step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = a;
            b_next    = b;
            m_next    = m;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next   = sum_red[MOD_W-1:0];
            a_next   = {a_reg[MOD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MCNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operand and partial result registers
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

/* sv/mexp_checker.sv */
// port-level checks for the modular exponentiation block, bound to the top level
module mexp_checker
    import mexp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [MOD_W-1:0] residue
);

    // a stalled result word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // a stalled result word holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(residue))
        else $error("result word changed while stalled");

    // one word at a time: input closes right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while a word is in flight");

    // residue never reaches the all-ones code, since it lies below the modulus or is one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> residue != {MOD_W{1'b1}})
        else $error("residue out of range");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .residue   (out_ch.residue)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for the modular exponentiation block with a residue scoreboard
module testbench
    import mexp_pkg::*;
();

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [MOD_W-1:0]   residue_t;

    localparam field_t   FIELD_MAX   = {FIELD_W{1'b1}};
    localparam residue_t MODULUS_MAX = {MOD_W{1'b1}};
    localparam int       LONG_HOLD   = 1500;
    localparam int       REPORT_MAX  = 10;

    // expected residues, predicted from each accepted word
    class residue_board;
        residue_t expected_q[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        // right-to-left square and multiply over the power bits
        function residue_t power_residue(field_t b, field_t p, residue_t m);
            logic [63:0] mm;
            logic [63:0] acc;
            logic [63:0] sq;
            field_t      e;
            if (p == '0)
                return residue_t'(1);
            mm  = (m == '0) ? 64'd1 : {33'd0, m};
            acc = 64'd1;
            sq  = {1'b0, b} % mm;
            e   = p;
            while (e != '0)
            begin
                if (e[0])
                    acc = ((acc % mm) * sq) % mm;
                sq = (sq * sq) % mm;
                e  = e >> 1;
            end
            return acc[MOD_W-1:0];
        endfunction

        function void note_word(field_t b, field_t p, residue_t m);
            expected_q.push_back(power_residue(b, p, m));
        endfunction

        function void check_word(residue_t got);
            residue_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected residue word %0d at %0t", got, $realtime);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("residue mismatch: expected %0d, got %0d at %0t",
                             want, got, $realtime);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    residue_t     cfg_wdata;
    residue_t     modulus_now;
    bit           sender_idles;
    bit           stalls_on;
    bit           long_hold_req;
    residue_board board;

    mexp_in_if  in_ch();
    mexp_out_if out_ch();

    modular_exponentiation u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #8000000;
        $display("TB_ERROR");
        $finish;
    end

    // note accepted input words
    always @(posedge clk)
    begin
        if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            board.note_word(in_ch.base_value, in_ch.power, modulus_now);
    end

    // check accepted result words
    always @(posedge clk)
    begin
        if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            board.check_word(out_ch.residue);
    end

    // result receiver: random stall bursts, calm stretches and one long hold-off
    initial
    begin : receiver
        int hold_left;
        int calm_left;
        hold_left    = 0;
        calm_left    = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            else if (hold_left == 0 && calm_left == 0 && stalls_on)
            begin
                case ($urandom_range(0, 15))
                    0:       calm_left = $urandom_range(20, 300);
                    1, 2:    hold_left = $urandom_range(1, 14);
                    default: ;
                endcase
            end
            if (hold_left != 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (calm_left != 0)
                    calm_left--;
            end
        end
    end

    // offer one word and wait for it to be taken; valid stays high afterwards
    task automatic send_word(input field_t b, input field_t p);
        if (sender_idles && $urandom_range(0, 2) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.base_value <= b;
        in_ch.power      <= p;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
    endtask

    // stop offering and wait until every expected residue has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // register write, only while the block is idle
    task automatic set_modulus(input residue_t m);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we      <= 1'b0;
        modulus_now  = m;
    endtask

    function automatic field_t random_base(residue_t m);
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return field_t'($urandom_range(0, 20));
            1:       return field_t'(m) + field_t'($urandom_range(0, 2)) - 1;
            default: return r[FIELD_W-1:0];
        endcase
    endfunction

    // mostly short powers keep the run fast; a few reach full width
    function automatic field_t random_power(int max_len);
        logic [63:0] r;
        int          len;
        r = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0)
            return '0;
        if (max_len > 24 && $urandom_range(0, 4) == 0)
            len = $urandom_range(25, max_len);
        else
            len = $urandom_range(1, (max_len < 24) ? max_len : 24);
        r = r & ((64'd1 << len) - 64'd1);
        r[len-1] = 1'b1;
        return r[FIELD_W-1:0];
    endfunction

    task automatic send_random_words(input int count, input int max_len);
        for (int i = 0; i < count; i++)
            send_word(random_base(modulus_now), random_power(max_len));
    endtask

    // stimulus
    initial
    begin : main
        board            = new();
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.base_value = '0;
        in_ch.power      = '0;
        modulus_now      = MODULUS_RESET;
        sender_idles     = 1'b1;
        stalls_on        = 1'b1;
        long_hold_req    = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words at the reset modulus
        send_word('0, '0);
        send_word('0, field_t'(1));
        send_word('0, FIELD_MAX);
        send_word(FIELD_MAX, '0);
        send_word(field_t'(1), FIELD_MAX);
        send_word(FIELD_MAX, field_t'(1));
        send_word(FIELD_MAX, FIELD_MAX);
        send_word(field_t'(2), field_t'(62));
        send_word(field_t'(MODULUS_RESET), field_t'(5));
        send_word(field_t'(MODULUS_RESET) - 1, field_t'(2));
        send_word(field_t'(MODULUS_RESET) + 1, FIELD_MAX);
        // fermat check on the prime reset modulus
        send_word(field_t'(3), field_t'(MODULUS_RESET) - 1);
        send_word(field_t'(2), field_t'(1) << (FIELD_W - 1));
        send_word(field_t'({(FIELD_W+1)/2{2'b01}}), field_t'({(FIELD_W+1)/2{2'b10}}));
        send_word(field_t'({(FIELD_W+1)/2{2'b10}}), field_t'({(FIELD_W+1)/2{2'b01}}));
        drain_results();

        // modulus of one: zero power still gives one
        set_modulus(residue_t'(1));
        send_word('0, '0);
        send_word(FIELD_MAX, '0);
        send_word(field_t'(5), field_t'(1));
        send_word(FIELD_MAX, FIELD_MAX);
        drain_results();

        // largest modulus
        set_modulus(MODULUS_MAX);
        send_word(FIELD_MAX, FIELD_MAX);
        send_word(field_t'(MODULUS_MAX) - 1, field_t'(2));
        send_word(field_t'(1) << MOD_W, field_t'(3));
        send_random_words(16, FIELD_W);
        drain_results();

        set_modulus(residue_t'(2));
        send_random_words(12, FIELD_W);
        drain_results();

        // long output hold-off with short powers so the block backs up
        set_modulus(residue_t'(65537));
        long_hold_req = 1'b1;
        send_random_words(6, 3);
        drain_results();
        send_random_words(10, FIELD_W);
        drain_results();

        set_modulus(residue_t'($urandom_range(1, 32'h7fff_ffff)));
        send_random_words(16, FIELD_W);
        drain_results();

        set_modulus(residue_t'(3));
        send_random_words(12, FIELD_W);
        drain_results();

        set_modulus(residue_t'($urandom_range(2, 1000)));
        send_random_words(14, FIELD_W);
        drain_results();

        set_modulus(residue_t'(1));
        send_random_words(8, FIELD_W);
        drain_results();

        // final stretch without idling on either side
        sender_idles = 1'b0;
        stalls_on    = 1'b0;
        set_modulus(MODULUS_RESET);
        send_random_words(24, FIELD_W);
        drain_results();

        repeat (200) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
